/* rtl/core/b64e_pkg.sv */
// ----------------------------------------------------------------------------
// b64e_pkg: shared types and constants for the base64 encoder with escaping
// Holds the character codes, the symbol alphabet lookup and the token
// bundle that passes from the encoder stage to the character serializer.
// ----------------------------------------------------------------------------
package b64e_pkg;

  typedef logic [7:0] char_t;
  typedef logic [5:0] sym_t;

  // Up to four base64 characters per input byte, first one in slot 0.
  localparam int unsigned MaxTokens = 4;
  localparam int unsigned TokCntW   = 3;

  typedef logic [MaxTokens-1:0][7:0] tok_vec_t;

  typedef struct packed {
    tok_vec_t             toks;
    logic [TokCntW-1:0]   cnt;
    logic                 msg_last;
  } enc_result_t;

  // Position of a byte within its three-byte group.
  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2,
    PhaseUnused = 2'd3
  } phase_t;

  // Which of the three escape characters is being sent for a plus sign.
  typedef enum logic [1:0] {
    EscPct  = 2'd0,
    EscTwo  = 2'd1,
    EscLowB = 2'd2
  } esc_idx_t;

  localparam char_t CharPlus  = 8'h2B;  // '+'
  localparam char_t CharPad   = 8'h3D;  // '='
  localparam char_t CharPct   = 8'h25;  // '%'
  localparam char_t CharTwo   = 8'h32;  // '2'
  localparam char_t CharLowB  = 8'h62;  // 'b'
  localparam char_t CharSlash = 8'h2F;  // '/'

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic char_t b64_char(input sym_t sym);
    char_t wide;
    wide = {2'b00, sym};
    if (sym < 6'd26) begin
      return wide + 8'h41;
    end else if (sym < 6'd52) begin
      return wide + 8'h47;          // 'a' minus 26
    end else if (sym < 6'd62) begin
      return wide + 8'hFC;          // '0' minus 52, modulo 256
    end else if (sym == 6'd62) begin
      return CharPlus;
    end else begin
      return CharSlash;
    end
  endfunction

endpackage

/* rtl/core/b64e_encode.sv */
// ----------------------------------------------------------------------------
// b64e_encode: group phase tracking and symbol generation
// Keeps the group phase and the leftover bits, and turns one byte into
// one to four base64 characters, including padding on the final byte.
// ----------------------------------------------------------------------------
module b64e_encode import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        load,
  output enc_result_t result
);

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] leftover;
  logic [3:0] leftover_next;

  always_comb begin
    result.toks     = '0;
    result.cnt      = TokCntW'(1);
    result.msg_last = last_byte;
    phase_next      = phase;
    leftover_next   = leftover;
    unique case (phase)
      PhaseSecond: begin
        result.toks[0] = b64_char({leftover[1:0], data_byte[7:4]});
        leftover_next  = data_byte[3:0];
        phase_next     = PhaseThird;
        if (last_byte) begin
          result.toks[1] = b64_char({data_byte[3:0], 2'b00});
          result.toks[2] = CharPad;
          result.cnt     = TokCntW'(3);
        end
      end
      PhaseThird: begin
        result.toks[0] = b64_char({leftover, data_byte[7:6]});
        result.toks[1] = b64_char(data_byte[5:0]);
        result.cnt     = TokCntW'(2);
        leftover_next  = 4'd0;
        phase_next     = PhaseFirst;
      end
      default: begin
        // The unused phase code behaves as the start of a group.
        result.toks[0] = b64_char(data_byte[7:2]);
        leftover_next  = {2'b00, data_byte[1:0]};
        phase_next     = PhaseSecond;
        if (last_byte) begin
          result.toks[1] = b64_char({data_byte[1:0], 4'b0000});
          result.toks[2] = CharPad;
          result.toks[3] = CharPad;
          result.cnt     = TokCntW'(4);
        end
      end
    endcase
    if (last_byte) begin
      phase_next    = PhaseFirst;
      leftover_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PhaseFirst;
      leftover <= 4'd0;
    end else if (load) begin
      phase    <= phase_next;
      leftover <= leftover_next;
    end
  end

endmodule

/* rtl/core/b64e_serial.sv */
// ----------------------------------------------------------------------------
// b64e_serial: character output register and serializer
// Holds the characters of one byte and sends them one per word, expanding
// each plus sign into the three-character escape.
// ----------------------------------------------------------------------------
module b64e_serial import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  enc_result_t result,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        load,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last_char
);

  tok_vec_t           toks;
  logic [TokCntW-1:0] cnt;
  esc_idx_t           esc;
  esc_idx_t           esc_next;
  logic               msg_last;

  logic is_plus;
  logic final_sub;
  logic take;
  logic drain;

  assign is_plus   = (toks[0] == CharPlus);
  assign final_sub = !is_plus || (esc == EscLowB);
  assign out_valid = (cnt != '0);
  assign take      = out_valid && out_ready;
  assign drain     = take && (cnt == TokCntW'(1)) && final_sub;
  assign in_ready  = (cnt == '0) || drain;
  assign load      = in_valid && in_ready;
  assign last_char = msg_last && (cnt == TokCntW'(1)) && final_sub;

  always_comb begin
    out_char = toks[0];
    esc_next = EscPct;
    if (is_plus) begin
      unique case (esc)
        EscPct: begin
          out_char = CharPct;
          esc_next = EscTwo;
        end
        EscTwo: begin
          out_char = CharTwo;
          esc_next = EscLowB;
        end
        default: begin
          out_char = CharLowB;
          esc_next = EscPct;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      esc <= EscPct;
    end else if (load) begin
      cnt <= result.cnt;
      esc <= EscPct;
    end else if (take) begin
      if (final_sub) begin
        cnt <= cnt - TokCntW'(1);
        esc <= EscPct;
      end else begin
        esc <= esc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      toks     <= result.toks;
      msg_last <= result.msg_last;
    end else if (take && final_sub) begin
      toks <= {8'h00, toks[MaxTokens-1:1]};
    end
  end

endmodule

/* rtl/core/base64_encoder_plus_escape.sv */
// ----------------------------------------------------------------------------
// base64_encoder_plus_escape: streaming base64 encoder with plus escaping
// Encodes a byte stream into standard base64 characters, pads the final
// group with '=' and sends every '+' as the three characters "%2b".
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word contents                      Marker
//  s_*       in         tdata[7:0] = data_byte             tlast = last_byte
//  m_*       out        tdata[7:0] = out_char              tlast = last_char
//
// Each accepted byte turns into one to four base64 characters, and each of
// those leaving as a plus sign becomes three characters, so a byte yields one
// to six output words. The output port moves one character per cycle while
// m_tready is high, which sets the rate; the output is about four characters
// for every three bytes of text without plus signs.
// The next byte is taken in the same cycle as the last character of the
// current byte leaves. Reset clears the group phase and the output buffer.
// A stall on m_tready holds the current character, and s_tready stays low
// for as long as the stall lasts, because a new byte only enters with the
// last character of the current one.
//
module base64_encoder_plus_escape import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_char
  output logic       m_tlast    // last_char
);

  enc_result_t result;
  logic        load;

  // Group phase, leftover bits and the characters for the incoming byte.
  b64e_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .load      (load),
    .result    (result)
  );

  // Result register holding the characters of one byte; the escape of a
  // plus sign is expanded as the characters leave.
  b64e_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .load      (load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .last_char (m_tlast)
  );

endmodule
